// ----- rtl/core/ctcf_pkg.sv -----
// shared types and constants for the change-triggered capture framer
// no dependencies; imported by every module of the block
`default_nettype none

package ctcf_pkg;

  typedef struct packed {
    logic [7:0]  port_value;
    logic [15:0] elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_t;

  // command kinds passed from front to back
  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_BURST   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  pin;
    logic [31:0] ticks;
  } cmd_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [15:0] TICK_SCALE_RESET = 16'd8;

  localparam logic [7:0] FRAME_START  = 8'h40;
  localparam logic [7:0] FRAME_END    = 8'h3B;
  localparam logic [7:0] ASCII_OFFSET = 8'h30;

  // byte positions within one frame
  localparam logic [2:0] POS_START = 3'd0;
  localparam logic [2:0] POS_PIN   = 3'd1;
  localparam logic [2:0] POS_T3    = 3'd2;
  localparam logic [2:0] POS_T2    = 3'd3;
  localparam logic [2:0] POS_T1    = 3'd4;
  localparam logic [2:0] POS_T0    = 3'd5;
  localparam logic [2:0] POS_END   = 3'd6;

endpackage

`default_nettype wire

// ----- rtl/core/ctcf_front.sv -----
// front end: takes loop passes, tracks mode, tick counter and capture count
// depends on ctcf_pkg; issues capture and burst commands to the queue
`default_nettype none

module ctcf_front import ctcf_pkg::*; #(
  parameter int SAMPLES = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);

  localparam int CW = $clog2(SAMPLES + 1);

  typedef enum logic [2:0] {
    MODE_MONITOR  = 3'b001,
    MODE_SAMPLING = 3'b010,
    MODE_SENDING  = 3'b100
  } mode_t;

  mode_t       mode;
  logic [7:0]  last_port;
  logic [CW-1:0] capture_count;
  logic [31:0] tick_counter;

  logic          accept;
  logic [31:0]   tick_sum;
  logic [31:0]   capture_ticks;
  logic [CW-1:0] count_inc;

  // monitor passes never need the queue
  assign in_stall = q_full && (mode != MODE_MONITOR);
  assign accept   = in_valid && !in_stall;

  assign tick_sum      = tick_counter + {16'd0, in_data.elapsed_ticks};
  assign capture_ticks = (capture_count == '0) ? 32'd0 : tick_sum;
  assign count_inc     = capture_count + CW'(1);

  always_comb begin
    q_push      = 1'b0;
    q_cmd.kind  = CMD_CAPTURE;
    q_cmd.pin   = in_data.port_value;
    q_cmd.ticks = capture_ticks;
    case (mode)
      MODE_SAMPLING: q_push = accept;
      MODE_SENDING: begin
        q_push     = accept;
        q_cmd.kind = CMD_BURST;
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_MONITOR;
      last_port     <= '0;
      capture_count <= '0;
      tick_counter  <= '0;
    end else if (accept) begin
      case (mode)
        MODE_SAMPLING: begin
          tick_counter  <= capture_ticks;
          capture_count <= count_inc;
          mode <= (count_inc >= CW'(SAMPLES)) ? MODE_SENDING : MODE_MONITOR;
        end
        MODE_SENDING: begin
          tick_counter  <= '0;
          capture_count <= '0;
          mode          <= MODE_MONITOR;
        end
        default: begin
          tick_counter <= tick_sum;
          last_port    <= in_data.port_value;
          mode <= (last_port != in_data.port_value) ? MODE_SAMPLING : MODE_MONITOR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ctcf_queue.sv -----
// short command queue between front and back
// depends on ctcf_pkg for the command type and depth
`default_nettype none

module ctcf_queue import ctcf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  fill;

  logic do_push;
  logic do_pop;

  assign full       = (fill == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ctcf_back.sv -----
// back end: capture store, timestamp scaling and frame serialiser
// depends on ctcf_pkg; drains commands from the queue, drives the output register
`default_nettype none

module ctcf_back import ctcf_pkg::*; #(
  parameter int SAMPLES = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data
);

  localparam int IW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_SEND = 2'b10
  } bk_state_t;

  bk_state_t   state;
  logic [15:0] tick_scale;
  logic [7:0]  store_pin  [SAMPLES];
  logic [31:0] store_time [SAMPLES];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] frame_idx;
  logic [2:0]    pos;

  logic        out_free;
  logic        load;
  logic [31:0] product;
  logic [7:0]  cur_pin;
  logic [31:0] cur_time;
  logic        final_frame;
  out_t        next_out;

  assign q_pop    = (state == BK_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;
  assign load     = (state == BK_SEND) && out_free;
  // timestamp wraps at 32 bits
  assign product  = q_cmd.ticks * {16'd0, tick_scale};

  assign cur_pin     = store_pin[frame_idx];
  assign cur_time    = store_time[frame_idx];
  assign final_frame = (frame_idx == IW'(SAMPLES - 1));

  always_comb begin
    next_out.last_byte = 1'b0;
    case (pos)
      POS_START: next_out.frame_byte = FRAME_START;
      POS_PIN:   next_out.frame_byte = cur_pin + ASCII_OFFSET;
      POS_T3:    next_out.frame_byte = cur_time[31:24] + ASCII_OFFSET;
      POS_T2:    next_out.frame_byte = cur_time[23:16] + ASCII_OFFSET;
      POS_T1:    next_out.frame_byte = cur_time[15:8] + ASCII_OFFSET;
      POS_T0:    next_out.frame_byte = cur_time[7:0] + ASCII_OFFSET;
      POS_END: begin
        next_out.frame_byte = FRAME_END;
        next_out.last_byte  = final_frame;
      end
      default:   next_out.frame_byte = FRAME_END;
    endcase
  end

  // capture store and output payload, no reset
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.kind == CMD_CAPTURE)) begin
      store_pin[wr_ptr]  <= q_cmd.pin;
      store_time[wr_ptr] <= product;
    end
    if (load) begin
      out_data <= next_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_scale <= TICK_SCALE_RESET;
      state      <= BK_IDLE;
      wr_ptr     <= '0;
      frame_idx  <= '0;
      pos        <= POS_START;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_scale <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_SEND: begin
          if (load) begin
            if (pos == POS_END) begin
              pos <= POS_START;
              if (final_frame) begin
                state <= BK_IDLE;
              end else begin
                frame_idx <= frame_idx + IW'(1);
              end
            end else begin
              pos <= pos + 3'd1;
            end
          end
        end
        default: begin
          if (q_pop) begin
            if (q_cmd.kind == CMD_BURST) begin
              state     <= BK_SEND;
              frame_idx <= '0;
              pos       <= POS_START;
              wr_ptr    <= '0;
            end else begin
              wr_ptr <= wr_ptr + IW'(1);
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/change_triggered_capture_framer_core.sv -----
// top level of the change-triggered capture framer
// depends on ctcf_pkg, ctcf_front, ctcf_queue and ctcf_back
`default_nettype none

// channel   direction  handshake            payload
// in        sink       in_valid/in_stall    in_t  {port_value, elapsed_ticks}
// out       source     out_valid/out_stall  out_t {frame_byte, last_byte}
// cfg       sink       cfg_we               cfg_wdata -> tick_scale
//
// the front takes one loop pass per cycle; monitor passes never stall
// sampling and sending passes stall only while the two-entry command queue is full
// the back writes each capture into the store with the scale multiply as it pops it; a burst
// leaves the queue and then sends 7 * SAMPLES bytes, one byte per cycle as the
// output register frees
// reset is synchronous on rst: monitor mode, counters cleared, scale back to 8
// the capture store is not reset; a burst only reads entries written before it

module change_triggered_capture_framer_core import ctcf_pkg::*; #(
  parameter int SAMPLES = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  // front to queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head_cmd;

  // classifies passes and issues capture / burst requests
  ctcf_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // decouples the pass rate from output backpressure
  ctcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // stores captures and serialises bursts into frame bytes
  ctcf_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_head_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
